// ----- rtl/flru_pkg.sv -----
// Shared types and constants for the FIFO/LRU page replacement counter.
package flru_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 32;

  localparam logic [0:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [0:0] CFG_PAGE_SIZE   = 1'b1;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage

// ----- rtl/fifo_lru_page_replacement_counter.sv -----
// Top level: page number by the divider, then sequenced scans of both tables.
// Per item: accept and divide, FIFO scan with eviction and insert on a miss, LRU scan with
// rank update on a hit, LRU eviction and insert on a miss, then the output state; each extra
// eviction after a lowered frame count adds a rescan. Throughput: one item at a time; tready
// is low from the transfer until the result is taken. Reset (rst, synchronous): tables empty,
// counters zero, frame_count 4, page_size 4096.
module fifo_lru_page_replacement_counter #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[31:0]
  input  logic        s_axis_tuser,   // new_run
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // fifo_hit, lru_hit, fifo_repl[31:0],
                                      // lru_repl[31:0], fifo_worse, zero pad
);
  import flru_pkg::*;

  localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FW = $clog2(MAX_FRAMES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FSCN = 3'd2;
  localparam logic [2:0] ST_LSCN = 3'd3;
  localparam logic [2:0] ST_LVIC = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]        state;
  logic [4:0]        frame_count;
  logic [31:0]       page_size;
  logic [31:0]       page;
  logic [IW-1:0]     k;
  logic [IW-1:0]     victim;
  logic [IW-1:0]     hit_idx;
  logic              fifo_hit, lru_hit, found;
  logic [FW-1:0]     fifo_fill, lru_fill, cap;
  logic [IW-1:0]     fifo_oldest;
  logic [31:0]       fifo_page [MAX_FRAMES];
  logic [31:0]       lru_page  [MAX_FRAMES];
  logic [IW-1:0]     lru_rank  [MAX_FRAMES];
  logic [CNT_W-1:0]  fifo_cnt, lru_cnt;
  div_ctl_t          dctl;
  div_sts_t          dsts;
  logic [31:0]       quot;
  logic [IW-1:0]     fslot, fnew, last;

  // fold a sum below 2*MAX_FRAMES back into the slot range
  function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] s);
    if (s >= (IW+1)'(MAX_FRAMES)) return IW'(s - (IW+1)'(MAX_FRAMES));
    return IW'(s);
  endfunction

  flru_div u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .dividend(s_axis_tdata), .divisor(page_size),
    .sts(dsts), .quotient(quot)
  );

  always_comb begin
    if (frame_count == 5'd0) cap = FW'(1);
    else if (32'(frame_count) > MAX_FRAMES) cap = FW'(MAX_FRAMES);
    else cap = FW'(frame_count);
  end

  // circular slot arithmetic modulo MAX_FRAMES
  always_comb begin
    fslot = wrap_slot({1'b0, fifo_oldest} + {1'b0, k});
    fnew  = wrap_slot({1'b0, fifo_oldest} + (IW+1)'(fifo_fill));
    last  = IW'(lru_fill - FW'(1));
  end

  assign dctl.start    = (state == ST_IDLE) && s_axis_tvalid;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {5'd0, (fifo_cnt > lru_cnt), lru_cnt, fifo_cnt, lru_hit, fifo_hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      frame_count <= 5'd4;
      page_size   <= 32'd4096;
      fifo_fill   <= '0;
      fifo_oldest <= '0;
      lru_fill    <= '0;
      fifo_cnt    <= '0;
      lru_cnt     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_COUNT) frame_count <= cfg_wdata[4:0];
        else page_size <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser) begin
              fifo_fill   <= '0;
              fifo_oldest <= '0;
              lru_fill    <= '0;
              fifo_cnt    <= '0;
              lru_cnt     <= '0;
            end
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dsts.done) begin
            page     <= quot;
            k        <= '0;
            fifo_hit <= 1'b0;
            state    <= ST_FSCN;
          end
        end
        ST_FSCN: begin
          if (FW'(k) < fifo_fill && fifo_page[fslot] == page) begin
            fifo_hit <= 1'b1;
            k        <= '0;
            found    <= 1'b0;
            state    <= ST_LSCN;
          end else if (FW'(k) + FW'(1) < fifo_fill) begin
            k <= k + IW'(1);
          end else if (fifo_fill >= cap) begin
            // evict oldest, count it, look again
            fifo_oldest <= wrap_slot({1'b0, fifo_oldest} + (IW+1)'(1));
            fifo_fill   <= fifo_fill - FW'(1);
            if (fifo_cnt != '1) fifo_cnt <= fifo_cnt + CNT_W'(1);
            k <= '0;
            state <= ST_FSCN;
            fifo_hit <= 1'b0;
          end else begin
            fifo_page[fnew] <= page;
            fifo_fill <= fifo_fill + FW'(1);
            k     <= '0;
            found <= 1'b0;
            state <= ST_LSCN;
          end
        end
        ST_LSCN: begin
          if (!found && FW'(k) < lru_fill && lru_page[k] == page) begin
            found   <= 1'b1;
            hit_idx <= k;
            k       <= '0;
          end else if (found) begin
            // age everything younger than the hit, one per cycle
            if (lru_rank[k] < lru_rank[hit_idx]) lru_rank[k] <= lru_rank[k] + IW'(1);
            if (FW'(k) + FW'(1) < lru_fill) k <= k + IW'(1);
            else begin
              lru_rank[hit_idx] <= '0;
              lru_hit <= 1'b1;
              state   <= ST_OUT;
            end
          end else if (FW'(k) + FW'(1) < lru_fill) begin
            k <= k + IW'(1);
          end else begin
            lru_hit <= 1'b0;
            k       <= '0;
            victim  <= '0;
            state   <= ST_LVIC;
          end
        end
        ST_LVIC: begin
          if (lru_fill >= cap && lru_fill != '0) begin
            // search oldest, then move last slot into the victim
            if (FW'(k) + FW'(1) < lru_fill) begin
              if (lru_rank[k + IW'(1)] > lru_rank[victim]) victim <= k + IW'(1);
              k <= k + IW'(1);
            end else begin
              lru_page[victim] <= lru_page[last];
              lru_rank[victim] <= lru_rank[last];
              lru_fill <= lru_fill - FW'(1);
              if (lru_cnt != '1) lru_cnt <= lru_cnt + CNT_W'(1);
              k <= '0;
              victim <= '0;
            end
          end else begin
            for (int i = 0; i < MAX_FRAMES; i++)
              if (FW'(i) < lru_fill) lru_rank[i] <= lru_rank[i] + IW'(1);
            lru_page[IW'(lru_fill)] <= page;
            lru_rank[IW'(lru_fill)] <= '0;
            lru_fill <= lru_fill + FW'(1);
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/flru_div.sv -----
// Restoring divider, one quotient bit per cycle.
module flru_div (
  input  logic                         clk,
  input  logic                         rst,
  input  flru_pkg::div_ctl_t           ctl,
  input  logic [flru_pkg::ADDR_W-1:0]  dividend,
  input  logic [flru_pkg::ADDR_W-1:0]  divisor,
  output flru_pkg::div_sts_t           sts,
  output logic [flru_pkg::ADDR_W-1:0]  quotient
);
  import flru_pkg::*;

  logic [ADDR_W-1:0] rem;
  logic [ADDR_W-1:0] dvs;
  logic [5:0]        steps;
  logic              busy;
  logic              done;
  logic [ADDR_W:0]   shifted;
  logic [ADDR_W+1:0] diff;

  // shifted can reach 2^33-3, so keep a separate borrow bit
  assign shifted = {rem, quotient[ADDR_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy     <= 1'b1;
        steps    <= 6'(ADDR_W);
        rem      <= '0;
        quotient <= dividend;
        dvs      <= (divisor == '0) ? ADDR_W'(1) : divisor;
      end else if (busy) begin
        if (!diff[ADDR_W+1]) begin
          rem      <= diff[ADDR_W-1:0];
          quotient <= {quotient[ADDR_W-2:0], 1'b1};
        end else begin
          rem      <= shifted[ADDR_W-1:0];
          quotient <= {quotient[ADDR_W-2:0], 1'b0};
        end
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule

// ----- rtl/flru_checker.sv -----
// Port-level checks for the page replacement counter.
module flru_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_worse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[66] == (m_axis_tdata[33:2] > m_axis_tdata[65:34])))
    else $error("fifo_worse mismatch");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after transfer");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
endmodule

bind fifo_lru_page_replacement_counter flru_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ----- sim/fifo_lru_page_replacement_counter_tb.sv -----
// Testbench for the FIFO/LRU page replacement counter: scoreboarded random and directed traffic.
`timescale 1ns / 1ps

module fifo_lru_page_replacement_counter_tb;
  import flru_pkg::*;

  localparam int NFR = 16;

  typedef struct packed {
    logic        fifo_worse;
    logic [31:0] lru_repl;
    logic [31:0] fifo_repl;
    logic        lru_hit;
    logic        fifo_hit;
  } paging_result_t;

  // Predictor of both replacement tables plus the queue of predicted results.
  class paging_tracker;
    logic [4:0]  frames_cfg;
    logic [31:0] page_bytes;
    logic [31:0] fifo_pg[NFR];
    int unsigned fifo_fill, fifo_head;
    logic [31:0] lru_pg[NFR];
    int unsigned lru_rank[NFR];
    int unsigned lru_fill;
    logic [31:0] fifo_evicts, lru_evicts;
    paging_result_t pending[$];
    int errors;

    function new();
      frames_cfg = 5'd4;
      page_bytes = 32'd4096;
      errors = 0;
      clear_tables();
    endfunction

    function void clear_tables();
      fifo_fill = 0; fifo_head = 0; lru_fill = 0;
      fifo_evicts = '0; lru_evicts = '0;
      foreach (lru_rank[i]) lru_rank[i] = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [31:0] val);
      if (idx == CFG_FRAME_COUNT) frames_cfg = val[4:0];
      else page_bytes = val;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void note_access(logic [31:0] addr, logic restart);
      paging_result_t r;
      logic [31:0] pg;
      int unsigned lim, k, j, rk, victim;
      logic hit;
      if (restart) clear_tables();
      pg = addr / ((page_bytes == 0) ? 32'd1 : page_bytes);
      lim = (frames_cfg == 0) ? 1 : ((frames_cfg > NFR) ? NFR : frames_cfg);
      hit = 0;
      for (k = 0; k < fifo_fill; k++)
        if (fifo_pg[(fifo_head + k) % NFR] == pg) hit = 1;
      if (!hit) begin
        while (fifo_fill >= lim && fifo_fill > 0) begin
          fifo_head = (fifo_head + 1) % NFR;
          fifo_fill--;
          fifo_evicts = bump(fifo_evicts);
        end
        fifo_pg[(fifo_head + fifo_fill) % NFR] = pg;
        fifo_fill++;
      end
      r.fifo_hit = hit;
      hit = 0;
      for (k = 0; k < lru_fill && !hit; k++)
        if (lru_pg[k] == pg) begin
          rk = lru_rank[k];
          for (j = 0; j < lru_fill; j++) if (lru_rank[j] < rk) lru_rank[j]++;
          lru_rank[k] = 0;
          hit = 1;
        end
      if (!hit) begin
        while (lru_fill >= lim && lru_fill > 0) begin
          victim = 0;
          for (k = 1; k < lru_fill; k++) if (lru_rank[k] > lru_rank[victim]) victim = k;
          lru_fill--;
          lru_pg[victim] = lru_pg[lru_fill];
          lru_rank[victim] = lru_rank[lru_fill];
          lru_evicts = bump(lru_evicts);
        end
        for (k = 0; k < lru_fill; k++) lru_rank[k]++;
        lru_pg[lru_fill] = pg;
        lru_rank[lru_fill] = 0;
        lru_fill++;
      end
      r.lru_hit = hit;
      r.fifo_repl = fifo_evicts;
      r.lru_repl = lru_evicts;
      r.fifo_worse = fifo_evicts > lru_evicts;
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic [71:0] data);
      paging_result_t got, exp;
      got = data[66:0];
      if (pending.size() == 0) begin
        $error("result with no prediction waiting: %h", data);
        errors++;
        return;
      end
      exp = pending[0];
      pending.delete(0);
      if (got.fifo_hit !== exp.fifo_hit) begin
        $error("fifo_hit exp %0d got %0d", exp.fifo_hit, got.fifo_hit); errors++;
      end
      if (got.lru_hit !== exp.lru_hit) begin
        $error("lru_hit exp %0d got %0d", exp.lru_hit, got.lru_hit); errors++;
      end
      if (got.fifo_repl !== exp.fifo_repl) begin
        $error("fifo_replacements exp %0d got %0d", exp.fifo_repl, got.fifo_repl); errors++;
      end
      if (got.lru_repl !== exp.lru_repl) begin
        $error("lru_replacements exp %0d got %0d", exp.lru_repl, got.lru_repl); errors++;
      end
      if (got.fifo_worse !== exp.fifo_worse) begin
        $error("fifo_worse exp %0d got %0d", exp.fifo_worse, got.fifo_worse); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [71:0] m_axis_tdata;

  paging_tracker tracker;
  int idle_cycles;
  bit drain_done;

  fifo_lru_page_replacement_counter #(.MAX_FRAMES(NFR)) dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Keep tvalid high into the next item when there is no gap.
  task automatic send_access(logic [31:0] addr, logic restart);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= addr; s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_access(addr, restart);
  endtask

  // Block until every prediction is matched, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Receiver with random stalls.
  initial begin
    int g;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !drain_done) begin
      $display("fifo_lru_page_replacement_counter_tb: errors");
      $finish;
    end
  end

  // Addresses mostly from a small working set of pages so hits happen often.
  function automatic logic [31:0] pick_addr(int span);
    int p;
    p = $urandom_range(0, 9);
    if (p < 8) return $urandom_range(0, span) * tracker.page_bytes + $urandom_range(0, 7);
    return $urandom();
  endfunction

  initial begin
    logic [4:0]  fr_set[6];
    logic [31:0] ps_set[6];
    int n, ph;
    tracker = new();
    drain_done = 0;
    idle_cycles = 0;
    rst = 1; cfg_we = 0; cfg_index = CFG_FRAME_COUNT; cfg_wdata = '0;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Classic reference string with reset settings, then extremes.
    foreach (ps_set[i]) ps_set[i] = 0;
    send_access(32'h0000_1000, 1);
    send_access(32'h0000_2000, 0);
    send_access(32'h0000_3000, 0);
    send_access(32'h0000_4000, 0);
    send_access(32'h0000_1000, 0);
    send_access(32'h0000_5000, 0);
    send_access(32'h0000_2fff, 0);
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h0000_0000, 0);
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 32'd0);
    write_reg(CFG_PAGE_SIZE, 32'd0);
    send_access(32'd7, 0);
    send_access(32'd7, 0);
    send_access(32'd8, 0);
    send_access(32'hFFFF_FFFF, 0);
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 32'd31);
    write_reg(CFG_PAGE_SIZE, 32'hFFFF_FFFF);
    send_access(32'hFFFF_FFFF, 1);
    send_access(32'hFFFF_FFFE, 0);
    send_access(32'd0, 0);
    wait_drained();
    write_reg(CFG_FRAME_COUNT, 32'd16);
    write_reg(CFG_PAGE_SIZE, 32'd1);
    for (int i = 0; i < 5; i++) send_access(i, 0);
    wait_drained();
    // Lower the frame count mid-run: the next miss evicts several.
    write_reg(CFG_FRAME_COUNT, 32'd2);
    send_access(32'd3, 0);
    send_access(32'd99, 0);
    wait_drained();

    fr_set = '{5'd1, 5'd3, 5'd4, 5'd8, 5'd16, 5'd20};
    ps_set = '{32'd1, 32'd3, 32'd64, 32'd4096, 32'h8000_0000, 32'h0001_0000};
    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FRAME_COUNT, (ph == 6) ? 32'd0 : fr_set[$urandom_range(0, 5)]);
      write_reg(CFG_PAGE_SIZE, ps_set[$urandom_range(0, 5)]);
      n = 0;
      while (n < 200) begin
        send_access(pick_addr(tracker.frames_cfg + 4), $urandom_range(0, 59) == 0);
        n++;
      end
      wait_drained();
    end

    drain_done = 1;
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("fifo_lru_page_replacement_counter_tb: clean");
    else
      $display("fifo_lru_page_replacement_counter_tb: errors");
    $finish;
  end
endmodule
